/* src/drfl_pkg.sv */
// Shared types, constants and date helpers for the dated rate floor lookup.
// No dependencies.
package drfl_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 23;
    localparam int RATE_W      = 40;
    localparam int AMT_W       = 22;
    localparam int PROD_W      = 60;
    localparam int ST_W        = 3;
    localparam int QDEPTH      = 2;
    localparam logic [AMT_W-1:0] AMOUNT_LIMIT = 22'd1024000;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_BAD_DATE = 3'd1;
    localparam logic [ST_W-1:0] ST_NEG_AMT  = 3'd2;
    localparam logic [ST_W-1:0] ST_BIG_AMT  = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

    // Classified request passed from front to back
    typedef struct packed {
        logic              is_query;
        logic              done;      // result settled at the front
        logic [ST_W-1:0]   status;
        logic [KEY_W-1:0]  key;
        logic [RATE_W-1:0] rate;
        logic [AMT_W-1:0]  amount;
    } drfl_req_t;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_WAIT, S_MUL, S_DONE
    } drfl_state_t;

    function automatic logic [4:0] month_len(input logic [6:0] m, input logic leap);
        logic [4:0] r;
        case (m)
            7'd2:                         r = leap ? 5'd29 : 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11:      r = 5'd30;
            default:                      r = 5'd31;
        endcase
        return r;
    endfunction

    function automatic logic is_leap(input logic [13:0] y);
        logic [13:0] r100;
        logic [13:0] q100;
        logic [27:0] prod;
        // divide by 100 via reciprocal: y*5243 >> 19, exact for y < 16384
        prod = 28'(y) * 28'd5243;
        q100 = {5'd0, prod[27:19]};
        r100 = y - 14'(q100 * 14'd100);
        return (y[1:0] == 2'b00) && ((r100 != 14'd0) || (q100[1:0] == 2'b00));
    endfunction

endpackage

/* src/drfl_front.sv */
// Front part: checks the date and amount and packs a request for the back.
// Depends on drfl_pkg.
module drfl_front import drfl_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [RATE_W+AMT_W+KEY_W+5:0] s_tdata,
    output logic                 q_valid,
    input  logic                 q_ready,
    output drfl_req_t            q_req
);
    logic        req_type;
    logic [13:0] yr;
    logic [6:0]  mo;
    logic [6:0]  dy;
    logic [RATE_W-1:0] rate;
    logic [AMT_W-1:0]  amt;
    logic        date_good;
    drfl_req_t   req_next;
    drfl_req_t   req_reg;
    logic        valid_reg;

    assign req_type = s_tdata[0];
    assign yr   = s_tdata[14:1];
    assign mo   = s_tdata[21:15];
    assign dy   = s_tdata[28:22];
    assign rate = s_tdata[68:29];
    assign amt  = s_tdata[90:69];

    // Classify the incoming beat
    always_comb begin
        date_good = (yr <= 14'd9999) && (mo >= 7'd1) && (mo <= 7'd12) && (dy >= 7'd1)
                    && (dy <= {2'b00, month_len(mo, is_leap(yr))});
        req_next.is_query = req_type;
        req_next.key      = {yr, mo[3:0], dy[4:0]};
        req_next.rate     = rate;
        req_next.amount   = amt;
        req_next.done     = 1'b1;
        req_next.status   = ST_OK;
        if (!date_good) begin
            req_next.status = ST_BAD_DATE;
        end else if (!req_type) begin
            req_next.done = 1'b0;
        end else if (amt[AMT_W-1]) begin
            req_next.status = ST_NEG_AMT;
        end else if (amt > AMOUNT_LIMIT) begin
            req_next.status = ST_BIG_AMT;
        end else begin
            req_next.done = 1'b0;
        end
    end

    assign s_tready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_req    = req_reg;

    // Hold the classified beat until the queue takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            req_reg <= req_next;
        end
    end
endmodule

/* src/drfl_queue.sv */
// Short request queue between front and back.
// Depends on drfl_pkg.
module drfl_queue import drfl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  drfl_req_t in_req,
    output logic      out_valid,
    input  logic      out_ready,
    output drfl_req_t out_req
);
    drfl_req_t mem_reg [QDEPTH];
    logic      wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic      push, pop;

    assign in_ready  = (cnt_reg != 2'(QDEPTH));
    assign out_valid = (cnt_reg != 2'd0);
    assign out_req   = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
        if (push) begin
            mem_reg[wp_reg] <= in_req;
        end
    end
endmodule

/* src/drfl_back.sv */
// Back part: scans the table, stores loads, finds the floor date and multiplies.
// Depends on drfl_pkg.
module drfl_back import drfl_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  drfl_req_t         q_req,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [ST_W+PROD_W:0] m_tdata
);
    logic [KEY_W+RATE_W-1:0] tab_mem [TABLE_DEPTH];
    logic [KEY_W+RATE_W-1:0] rd_reg;

    drfl_state_t state_reg, state_next;
    drfl_req_t   cur_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] idx_reg;      // address being read
    logic             rd_vld_reg;   // rd_reg holds entry idx_reg-1
    logic [IDX_W-1:0] rd_idx_reg;
    logic             hit_reg;
    logic [KEY_W-1:0] best_key_reg;
    logic [RATE_W-1:0] best_rate_reg;
    logic             match_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic [ST_W-1:0]  st_reg;
    logic [PROD_W-1:0] prod_reg;
    logic             fnd_reg;
    logic [1:0]       mcyc_reg;
    logic [PROD_W-1:0] acc_reg;

    logic [KEY_W-1:0]  rk;
    logic [RATE_W-1:0] rr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [20:0]       rslice;
    logic [PROD_W-1:0] part;

    assign rk = rd_reg[KEY_W+RATE_W-1:RATE_W];
    assign rr = rd_reg[RATE_W-1:0];

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (q_valid) state_next = q_req.done ? S_DONE : S_SCAN;
            S_SCAN: if (idx_reg == count_reg) state_next = S_WAIT;
            S_WAIT: state_next = (cur_reg.is_query && hit_reg) ? S_MUL : S_DONE;
            S_MUL:  if (mcyc_reg == 2'd1) state_next = S_DONE;
            S_DONE: if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        q_ready  = (state_reg == S_IDLE);
        m_tvalid = (state_reg == S_DONE);
        m_tdata  = {prod_reg, fnd_reg, st_reg};
        wr_en    = 1'b0;
        wr_addr  = count_reg[IDX_W-1:0];
        if (state_reg == S_WAIT && !cur_reg.is_query && cur_reg.status == ST_OK) begin
            if (match_reg) begin
                wr_en   = 1'b1;
                wr_addr = match_idx_reg;
            end else if (count_reg != CNT_W'(TABLE_DEPTH)) begin
                wr_en = 1'b1;
            end
        end
    end

    // Multiplier slice: 22 x 21 bits per cycle, low rate half first, then high half
    assign rslice = mcyc_reg[0] ? {1'b0, best_rate_reg[39:20]} : {1'b0, best_rate_reg[19:0]};
    assign part   = PROD_W'({21'd0, cur_reg.amount} * {22'd0, rslice});

    // Table memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tab_mem[wr_addr] <= {cur_reg.key, cur_reg.rate};
        end
        rd_reg <= tab_mem[idx_reg[IDX_W-1:0]];
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (wr_en && !match_reg) count_reg <= count_reg + 1'b1;
        end
        case (state_reg)
            S_IDLE: begin
                cur_reg    <= q_req;
                idx_reg    <= '0;
                rd_vld_reg <= 1'b0;
                hit_reg    <= 1'b0;
                match_reg  <= 1'b0;
                st_reg     <= q_req.status;
                fnd_reg    <= 1'b0;
                prod_reg   <= '0;
                mcyc_reg   <= 2'd0;
                acc_reg    <= '0;
            end
            S_SCAN, S_WAIT: begin
                if (idx_reg != count_reg) idx_reg <= idx_reg + 1'b1;
                rd_vld_reg <= (idx_reg != count_reg);
                rd_idx_reg <= idx_reg[IDX_W-1:0];
                if (rd_vld_reg) begin
                    if (rk == cur_reg.key) begin
                        match_reg     <= 1'b1;
                        match_idx_reg <= rd_idx_reg;
                    end
                    if (rk <= cur_reg.key && (!hit_reg || rk > best_key_reg)) begin
                        hit_reg       <= 1'b1;
                        best_key_reg  <= rk;
                        best_rate_reg <= rr;
                    end
                end
                if (state_reg == S_WAIT && !cur_reg.is_query && !match_reg
                    && count_reg == CNT_W'(TABLE_DEPTH)) begin
                    st_reg <= ST_FULL;
                end
            end
            S_MUL: begin
                mcyc_reg <= mcyc_reg + 2'd1;
                if (mcyc_reg == 2'd0) begin
                    acc_reg <= part;
                end else begin
                    prod_reg <= acc_reg + (part << 20);
                    fnd_reg  <= 1'b1;
                end
            end
            default: ;
        endcase
    end
endmodule

/* src/dated_rate_floor_lookup_core.sv */
// Top level of the dated rate floor lookup: front, queue and back.
// Depends on drfl_pkg, drfl_front, drfl_queue and drfl_back.
//
// Usage:
// Input beats on s_*: load (req_type 0) stores a rate under a date or
// overwrites it; query (req_type 1) returns amount times the rate of the
// latest stored date on or before the query date. Every beat gives one
// result beat on m_*.
// Timing: a beat rejected at the front (bad date, bad amount) skips the
// table walk. A table walk reads all count stored entries (count up to
// 1024) in turn, one read per cycle from the table memory, and a query
// hit then goes on to the multiply. One item is walked at a time; the
// front and a two-entry queue take up to three further beats meanwhile.
// Reset: aresetn low empties the table count and the queue; table contents
// need no clearing.
// Stall: when m_tready is low the result is held, the back stops, and the
// queue then the front fill and drop s_tready.
module dated_rate_floor_lookup_core import drfl_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // req_type, date_year, date_month, date_day, rate_in, amount_in, zero pad
    input  logic [95:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, found_earlier, product
    output logic [63:0]  m_tdata
);
    logic      fq_valid, fq_ready;
    drfl_req_t fq_req;
    logic      qb_valid, qb_ready;
    drfl_req_t qb_req;
    logic [ST_W+PROD_W:0] res;

    drfl_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready,
        .s_tdata(s_tdata[RATE_W+AMT_W+KEY_W+5:0]),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_req(fq_req)
    );

    drfl_queue u_queue (
        .aclk, .aresetn,
        .in_valid(fq_valid), .in_ready(fq_ready), .in_req(fq_req),
        .out_valid(qb_valid), .out_ready(qb_ready), .out_req(qb_req)
    );

    drfl_back u_back (
        .aclk, .aresetn,
        .q_valid(qb_valid), .q_ready(qb_ready), .q_req(qb_req),
        .m_tvalid, .m_tready, .m_tdata(res)
    );

    assign m_tdata = res;
endmodule
